[sv/vector_axis_rotator_top_macros.svh]
// assertion macros shared by the rotator rtl
// no dependencies; taken in by `include where assertions are written
`ifndef VECTOR_AXIS_ROTATOR_TOP_MACROS_SVH
`define VECTOR_AXIS_ROTATOR_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define VROT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vrot: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define VROT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vrot: next-cycle check failed");

`endif

[sv/vrot_pkg.sv]
// types, codes, constants and the arctangent table of the axis rotator
// no dependencies; imported by every rtl module of the block
package vrot_pkg;

    localparam int COMP_W            = 24;
    localparam int ANGLE_W           = 16;
    localparam int GUARD_BITS        = 8;
    localparam int ATAN_LEN          = 24;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int GAIN_W            = 32;
    localparam int PROD_W            = COMP_W + GAIN_W;
    localparam int GAIN_SHIFT        = 30 - GUARD_BITS;
    localparam int XW                = 34;
    localparam int ZW                = 32;
    localparam int ZSHIFT            = 16;
    localparam int TH_W              = ANGLE_W + 1;

    localparam logic signed [GAIN_W-1:0] GAIN_Q30   = 32'sd652032874;
    localparam logic signed [TH_W-1:0]   QUARTER    = 17'sd16384;
    localparam logic signed [TH_W-1:0]   HALF_TURN  = 17'sd32768;
    localparam logic signed [COMP_W-1:0] COMP_MAX   = 24'sd8388607;
    localparam logic signed [COMP_W-1:0] COMP_MIN   = -24'sd8388608;

    localparam logic signed [ZW-1:0] ATAN_TABLE [0:ATAN_LEN-1] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_CCW  = 2'd1,
        OP_CW   = 2'd2,
        OP_BAD  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        AX_X   = 2'd0,
        AX_Y   = 2'd1,
        AX_Z   = 2'd2,
        AX_BAD = 2'd3
    } t_axis;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_OP   = 2'd1,
        ST_BAD_AXIS = 2'd2
    } t_status;

    // what rides along the rotation pipeline untouched
    typedef struct packed {
        logic signed [COMP_W-1:0] a;
        logic signed [COMP_W-1:0] b;
        logic signed [COMP_W-1:0] c;
        t_axis                    plane;
        logic                     bypass;
        t_status                  status;
    } t_meta;

    // classified item handed from front to back
    typedef struct packed {
        t_meta                     meta;
        logic signed [ANGLE_W-1:0] theta;
        logic                      flip;
    } t_item;

endpackage

[sv/vrot_front.sv]
// front end: accepts items, decodes code and axis, picks the plane, folds the angle
// depends on vrot_pkg
module vrot_front
    import vrot_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_opcode,
    input  logic [1:0]                i_axis,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic signed [COMP_W-1:0]  i_in_x,
    input  logic signed [COMP_W-1:0]  i_in_y,
    input  logic signed [COMP_W-1:0]  i_in_z,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_item                     o_item
);

    logic                   r_vld;
    t_item                  r_item;
    t_item                  n_item;
    t_opcode                w_op;
    t_axis                  w_ax;
    logic signed [TH_W-1:0] w_ang;
    logic signed [TH_W-1:0] w_th;
    logic signed [TH_W-1:0] w_fold;

    assign w_op    = t_opcode'(i_opcode);
    assign w_ax    = t_axis'(i_axis);
    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_comb begin
        w_ang = {i_angle[ANGLE_W-1], i_angle};
        w_th  = (w_op == OP_CW) ? -w_ang : w_ang;
        // bring the angle within a quarter turn, the plane gets negated
        n_item.flip = 1'b0;
        w_fold      = w_th;
        if (w_th > QUARTER) begin
            w_fold      = w_th - HALF_TURN;
            n_item.flip = 1'b1;
        end else if (w_th < -QUARTER) begin
            w_fold      = w_th + HALF_TURN;
            n_item.flip = 1'b1;
        end
        n_item.theta = w_fold[ANGLE_W-1:0];

        n_item.meta.a      = i_in_x;
        n_item.meta.b      = i_in_y;
        n_item.meta.c      = i_in_z;
        n_item.meta.plane  = AX_Z;
        n_item.meta.bypass = 1'b1;
        n_item.meta.status = ST_OK;
        case (w_op)
            OP_NONE: begin
                n_item.meta.status = ST_OK;
            end
            OP_BAD: begin
                n_item.meta.status = ST_BAD_OP;
            end
            default: begin
                case (w_ax)
                    AX_X: begin
                        n_item.meta.a      = i_in_y;
                        n_item.meta.b      = i_in_z;
                        n_item.meta.c      = i_in_x;
                        n_item.meta.plane  = AX_X;
                        n_item.meta.bypass = 1'b0;
                    end
                    AX_Y: begin
                        n_item.meta.a      = i_in_z;
                        n_item.meta.b      = i_in_x;
                        n_item.meta.c      = i_in_y;
                        n_item.meta.plane  = AX_Y;
                        n_item.meta.bypass = 1'b0;
                    end
                    AX_Z: begin
                        n_item.meta.bypass = 1'b0;
                    end
                    default: begin
                        n_item.meta.status = ST_BAD_AXIS;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

[sv/vrot_queue.sv]
// short item queue between the front end and the rotation pipeline
// depends on vrot_pkg
module vrot_queue
    import vrot_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item            r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[sv/vrot_back.sv]
// back end: gain correction, cordic stages, rounding, saturation and output register
// depends on vrot_pkg
module vrot_back
    import vrot_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  t_item                    i_q_item,
    output logic                     o_q_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [COMP_W-1:0] o_out_x,
    output logic signed [COMP_W-1:0] o_out_y,
    output logic signed [COMP_W-1:0] o_out_z,
    output logic [1:0]               o_status,
    output logic                     o_saturated
);

    localparam int NS = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int RW = XW - GUARD_BITS;

    localparam logic signed [PROD_W-1:0] GAIN_RND = PROD_W'(1) <<< (GAIN_SHIFT - 1);
    localparam logic signed [XW-1:0]     OUT_RND  = XW'(1) <<< (GUARD_BITS - 1);

    // rounds off the guard bits and clamps; returns {saturated, value}
    function automatic logic [COMP_W:0] round_clamp(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] s;
        logic signed [RW-1:0] r;
        begin
            s = (v + OUT_RND) >>> GUARD_BITS;
            r = s[RW-1:0];
            if (r > RW'(COMP_MAX)) begin
                round_clamp = {1'b1, COMP_MAX};
            end else if (r < RW'(COMP_MIN)) begin
                round_clamp = {1'b1, COMP_MIN};
            end else begin
                round_clamp = {1'b0, r[COMP_W-1:0]};
            end
        end
    endfunction

    logic                     w_en;

    // gain stage
    logic                     r_vld_g;
    logic signed [PROD_W-1:0] r_pa;
    logic signed [PROD_W-1:0] r_pb;
    logic signed [ANGLE_W-1:0] r_th_g;
    logic                     r_flip_g;
    t_meta                    r_meta_g;

    // cordic chain, index 0 is the fold stage output
    logic                     r_vld [0:NS];
    logic signed [XW-1:0]     r_x   [0:NS];
    logic signed [XW-1:0]     r_y   [0:NS];
    logic signed [ZW-1:0]     r_z   [0:NS];
    t_meta                    r_meta[0:NS];

    logic signed [PROD_W-1:0] w_ra;
    logic signed [PROD_W-1:0] w_rb;
    logic signed [XW-1:0]     w_xa;
    logic signed [XW-1:0]     w_xb;

    // output register
    logic                     r_out_vld;
    logic signed [COMP_W-1:0] r_out_x;
    logic signed [COMP_W-1:0] r_out_y;
    logic signed [COMP_W-1:0] r_out_z;
    t_status                  r_out_st;
    logic                     r_out_sat;
    logic signed [COMP_W-1:0] n_out_x;
    logic signed [COMP_W-1:0] n_out_y;
    logic signed [COMP_W-1:0] n_out_z;
    logic                     n_out_sat;
    logic [COMP_W:0]          w_ca;
    logic [COMP_W:0]          w_cb;
    logic signed [COMP_W-1:0] w_fa;
    logic signed [COMP_W-1:0] w_fb;

    assign w_en    = !r_out_vld || i_ready;
    assign o_q_pop = w_en;

    // gain multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_g <= 1'b0;
        end else if (w_en) begin
            r_vld_g <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa     <= i_q_item.meta.a * GAIN_Q30;
            r_pb     <= i_q_item.meta.b * GAIN_Q30;
            r_th_g   <= i_q_item.theta;
            r_flip_g <= i_q_item.flip;
            r_meta_g <= i_q_item.meta;
        end
    end

    // round to guard bits, apply the half-turn fold, load the residual angle
    assign w_ra = (r_pa + GAIN_RND) >>> GAIN_SHIFT;
    assign w_rb = (r_pb + GAIN_RND) >>> GAIN_SHIFT;
    assign w_xa = w_ra[XW-1:0];
    assign w_xb = w_rb[XW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= r_vld_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0]    <= r_flip_g ? -w_xa : w_xa;
            r_y[0]    <= r_flip_g ? -w_xb : w_xb;
            r_z[0]    <= {r_th_g, ZSHIFT'(0)};
            r_meta[0] <= r_meta_g;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic signed [XW-1:0] w_dx;
            logic signed [XW-1:0] w_dy;
            logic                 w_pos;

            assign w_dx  = r_y[k] >>> k;
            assign w_dy  = r_x[k] >>> k;
            assign w_pos = !r_z[k][ZW-1];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else if (w_en) begin
                    r_vld[k+1] <= r_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_x[k+1]    <= w_pos ? r_x[k] - w_dx : r_x[k] + w_dx;
                    r_y[k+1]    <= w_pos ? r_y[k] + w_dy : r_y[k] - w_dy;
                    r_z[k+1]    <= w_pos ? r_z[k] - ATAN_TABLE[k] : r_z[k] + ATAN_TABLE[k];
                    r_meta[k+1] <= r_meta[k];
                end
            end
        end
    endgenerate

    // final rounding, clamp and reassembly of the vector
    always_comb begin
        w_ca = round_clamp(r_x[NS]);
        w_cb = round_clamp(r_y[NS]);
        if (r_meta[NS].bypass) begin
            w_fa      = r_meta[NS].a;
            w_fb      = r_meta[NS].b;
            n_out_sat = 1'b0;
        end else begin
            w_fa      = w_ca[COMP_W-1:0];
            w_fb      = w_cb[COMP_W-1:0];
            n_out_sat = w_ca[COMP_W] || w_cb[COMP_W];
        end
        case (r_meta[NS].plane)
            AX_X: begin
                n_out_x = r_meta[NS].c;
                n_out_y = w_fa;
                n_out_z = w_fb;
            end
            AX_Y: begin
                n_out_x = w_fb;
                n_out_y = r_meta[NS].c;
                n_out_z = w_fa;
            end
            default: begin
                n_out_x = w_fa;
                n_out_y = w_fb;
                n_out_z = r_meta[NS].c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x   <= n_out_x;
            r_out_y   <= n_out_y;
            r_out_z   <= n_out_z;
            r_out_st  <= r_meta[NS].status;
            r_out_sat <= n_out_sat;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_status    = r_out_st;
    assign o_saturated = r_out_sat;

endmodule

[sv/vector_axis_rotator_top.sv]
// top level of the 3d axis rotator: front end, item queue, cordic back end
// depends on vrot_pkg, vrot_front, vrot_queue, vrot_back and the assertion macros
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_opcode i_axis i_angle i_in_x i_in_y i_in_z
//  out     | o_out_valid | i_out_ready | o_out_x o_out_y o_out_z o_status o_saturated
//
// one item per cycle sustained while the output is not stalled; the unrolled cordic chain has one register per stage
// registers on the path: front, queue, gain, fold, stages, output
// reset is synchronous, active low, and empties the front, queue and pipeline valids
// a stalled output freezes the back end; the front keeps taking items until the queue fills
`include "vector_axis_rotator_top_macros.svh"

module vector_axis_rotator_top
    import vrot_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_opcode,
    input  logic [1:0]                i_axis,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic signed [COMP_W-1:0]  i_in_x,
    input  logic signed [COMP_W-1:0]  i_in_y,
    input  logic signed [COMP_W-1:0]  i_in_z,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [COMP_W-1:0]  o_out_x,
    output logic signed [COMP_W-1:0]  o_out_y,
    output logic signed [COMP_W-1:0]  o_out_z,
    output logic [1:0]                o_status,
    output logic                      o_saturated
);

    // front end to queue
    logic  w_front_vld;
    logic  w_q_ready;
    t_item w_front_item;

    // queue to back end
    logic  w_q_vld;
    logic  w_q_pop;
    t_item w_q_item;

    // decode, plane select and angle fold, one register deep
    vrot_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_opcode (i_opcode),
        .i_axis   (i_axis),
        .i_angle  (i_angle),
        .i_in_x   (i_in_x),
        .i_in_y   (i_in_y),
        .i_in_z   (i_in_z),
        .o_valid  (w_front_vld),
        .i_ready  (w_q_ready),
        .o_item   (w_front_item)
    );

    // decouples the front from back-end stalls
    vrot_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_vld),
        .o_ready (w_q_ready),
        .i_item  (w_front_item),
        .o_valid (w_q_vld),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item)
    );

    // gain correction, cordic rotation, rounding, saturation, output register
    vrot_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_vld),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_status    (o_status),
        .o_saturated (o_saturated)
    );

    // an error or pass-through item never reports clamping
    `VROT_ASSERT_IMP(a_err_no_sat, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), !o_saturated)
    // input back-pressure only comes from a held front register facing a full queue
    `VROT_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !o_in_ready, w_front_vld && !w_q_ready)
    // an accepted item lands in the front register
    `VROT_ASSERT_NXT(a_accept_lands, i_clk, i_rst_n, i_in_valid && o_in_ready, w_front_vld)

endmodule

[dv/tb_vector_axis_rotator_checker.sv]
// watches both channels of the 3d axis rotator, predicts each result and compares it
// depends on vrot_pkg; instantiated beside u_dut by tb_vector_axis_rotator_top
module tb_vector_axis_rotator_checker
    import vrot_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [1:0]                i_opcode,
    input  logic [1:0]                i_axis,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic signed [COMP_W-1:0]  i_in_x,
    input  logic signed [COMP_W-1:0]  i_in_y,
    input  logic signed [COMP_W-1:0]  i_in_z,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [COMP_W-1:0]  i_out_x,
    input  logic signed [COMP_W-1:0]  i_out_y,
    input  logic signed [COMP_W-1:0]  i_out_z,
    input  logic [1:0]                i_status,
    input  logic                      i_saturated,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);

    localparam int     TURN_STAGES = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam longint GAIN_K      = 64'sd652032874;
    localparam longint LIM_HI      = 64'sd8388607;
    localparam longint LIM_LO      = -64'sd8388608;

    typedef struct {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        t_status                  st;
        logic                     clamped;
    } t_rotated_vec;

    t_rotated_vec rotated_q[$];
    int           fails   = 0;
    int           checked = 0;

    // residual angle step per stage, units of pi * 2^-31
    function automatic longint arctan_step(int i);
        case (i)
            0:  return 64'sd536870912;
            1:  return 64'sd316933406;
            2:  return 64'sd167458907;
            3:  return 64'sd85004756;
            4:  return 64'sd42667331;
            5:  return 64'sd21354465;
            6:  return 64'sd10679838;
            7:  return 64'sd5340245;
            8:  return 64'sd2670163;
            9:  return 64'sd1335087;
            10: return 64'sd667544;
            11: return 64'sd333772;
            12: return 64'sd166886;
            13: return 64'sd83443;
            14: return 64'sd41722;
            15: return 64'sd20861;
            16: return 64'sd10430;
            17: return 64'sd5215;
            18: return 64'sd2608;
            19: return 64'sd1304;
            20: return 64'sd652;
            21: return 64'sd326;
            22: return 64'sd163;
            23: return 64'sd81;
            default: return 64'sd0;
        endcase
    endfunction

    function automatic longint clamp_comp(input longint v, inout bit clip);
        if (v > LIM_HI) begin
            clip = 1'b1;
            return LIM_HI;
        end
        if (v < LIM_LO) begin
            clip = 1'b1;
            return LIM_LO;
        end
        return v;
    endfunction

    // turns (a, b) by theta in units of pi / 32768, 8 guard bits inside
    function automatic void turn_plane(input longint a, input longint b, input longint theta,
                                       output longint ra, output longint rb, inout bit clip);
        longint pa;
        longint pb;
        longint resid;
        longint da;
        longint db;
        pa    = (a * GAIN_K + (64'sd1 <<< 21)) >>> 22;
        pb    = (b * GAIN_K + (64'sd1 <<< 21)) >>> 22;
        resid = theta;
        // fold beyond a quarter turn: negate the pair, move half a turn toward zero
        if (resid > 16384) begin
            pa    = -pa;
            pb    = -pb;
            resid = resid - 32768;
        end else if (resid < -16384) begin
            pa    = -pa;
            pb    = -pb;
            resid = resid + 32768;
        end
        resid = resid * 65536;
        for (int i = 0; i < TURN_STAGES; i++) begin
            da = pb >>> i;
            db = pa >>> i;
            if (resid >= 0) begin
                pa    = pa - da;
                pb    = pb + db;
                resid = resid - arctan_step(i);
            end else begin
                pa    = pa + da;
                pb    = pb - db;
                resid = resid + arctan_step(i);
            end
        end
        ra = clamp_comp((pa + 128) >>> 8, clip);
        rb = clamp_comp((pb + 128) >>> 8, clip);
    endfunction

    function automatic t_rotated_vec predict_rotation(t_opcode op, t_axis ax,
                                                      logic signed [ANGLE_W-1:0] ang,
                                                      logic signed [COMP_W-1:0] vx,
                                                      logic signed [COMP_W-1:0] vy,
                                                      logic signed [COMP_W-1:0] vz);
        t_rotated_vec r;
        longint       th;
        longint       pa;
        longint       pb;
        bit           clip;
        r.x     = vx;
        r.y     = vy;
        r.z     = vz;
        r.st    = ST_OK;
        r.clamped = 1'b0;
        clip    = 1'b0;
        pa      = 0;
        pb      = 0;
        if (op == OP_BAD) begin
            r.st = ST_BAD_OP;
        end else if (op != OP_NONE) begin
            th = ang;
            if (op == OP_CW) begin
                th = -th;
            end
            case (ax)
                AX_X: begin
                    turn_plane(vy, vz, th, pa, pb, clip);
                    r.y = pa[COMP_W-1:0];
                    r.z = pb[COMP_W-1:0];
                end
                AX_Y: begin
                    turn_plane(vz, vx, th, pa, pb, clip);
                    r.z = pa[COMP_W-1:0];
                    r.x = pb[COMP_W-1:0];
                end
                AX_Z: begin
                    turn_plane(vx, vy, th, pa, pb, clip);
                    r.x = pa[COMP_W-1:0];
                    r.y = pb[COMP_W-1:0];
                end
                default: r.st = ST_BAD_AXIS;
            endcase
            r.clamped = clip;
        end
        return r;
    endfunction

    task automatic note_mismatch(string field, logic [COMP_W-1:0] want, logic [COMP_W-1:0] got);
        fails++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field,
                 $signed(want), $signed(got));
    endtask

    always @(posedge i_clk) begin : watch
        t_rotated_vec want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                rotated_q.push_back(predict_rotation(t_opcode'(i_opcode), t_axis'(i_axis),
                                                     i_angle, i_in_x, i_in_y, i_in_z));
            end
            if (i_out_valid && i_out_ready) begin
                if (rotated_q.size() == 0) begin
                    fails++;
                    $display("%0t: result with none expected, x %0d y %0d z %0d",
                             $time, i_out_x, i_out_y, i_out_z);
                end else begin
                    want = rotated_q.pop_front();
                    checked++;
                    if (want.x !== i_out_x) note_mismatch("out_x", want.x, i_out_x);
                    if (want.y !== i_out_y) note_mismatch("out_y", want.y, i_out_y);
                    if (want.z !== i_out_z) note_mismatch("out_z", want.z, i_out_z);
                    if (want.st !== i_status) begin
                        note_mismatch("status", {22'd0, want.st}, {22'd0, i_status});
                    end
                    if (want.clamped !== i_saturated) begin
                        note_mismatch("saturated", {23'd0, want.clamped}, {23'd0, i_saturated});
                    end
                end
            end
        end
        o_pending    <= rotated_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

[dv/tb_vector_axis_rotator_top.sv]
// testbench top for the 3d axis rotator: clock, reset, stimulus, receiver pacing, verdict
// depends on vrot_pkg, vector_axis_rotator_top and tb_vector_axis_rotator_checker
module tb_vector_axis_rotator_top;
    import vrot_pkg::*;

    localparam int ROT_STAGES       = CORDIC_STAGES_DEF;
    // front, queue, gain, fold, stages and output register
    localparam int PIPE_DEPTH       = ROT_STAGES + 5;
    // a correct run with heavy idling on both sides stays well under this limit
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 560;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic [1:0]                i_opcode    = '0;
    logic [1:0]                i_axis      = '0;
    logic signed [ANGLE_W-1:0] i_angle     = '0;
    logic signed [COMP_W-1:0]  i_in_x      = '0;
    logic signed [COMP_W-1:0]  i_in_y      = '0;
    logic signed [COMP_W-1:0]  i_in_z      = '0;
    logic                      i_out_ready = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic signed [COMP_W-1:0]  o_out_x;
    logic signed [COMP_W-1:0]  o_out_y;
    logic signed [COMP_W-1:0]  o_out_z;
    logic [1:0]                o_status;
    logic                      o_saturated;

    int fail_count;
    int pending;
    int checked;

    // idle rates in percent, changed between phases
    int send_idle_pct = 7;
    int recv_idle_pct = 60;

    int cycle_count = 0;
    int items_sent  = 0;
    int n_rotate    = 0;
    int n_bypass    = 0;
    int n_error     = 0;

    always #5 i_clk = ~i_clk;

    vector_axis_rotator_top #(
        .CORDIC_STAGES(ROT_STAGES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_axis      (i_axis),
        .i_angle     (i_angle),
        .i_in_x      (i_in_x),
        .i_in_y      (i_in_y),
        .i_in_z      (i_in_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_status    (o_status),
        .o_saturated (o_saturated)
    );

    tb_vector_axis_rotator_checker #(
        .CORDIC_STAGES(ROT_STAGES)
    ) u_rotation_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_axis       (i_axis),
        .i_angle      (i_angle),
        .i_in_x       (i_in_x),
        .i_in_y       (i_in_y),
        .i_in_z       (i_in_z),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_x      (o_out_x),
        .i_out_y      (o_out_y),
        .i_out_z      (o_out_z),
        .i_status     (o_status),
        .i_saturated  (o_saturated),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // offers one item, with random idle cycles in front of it, and returns once it is taken;
    // valid is written once per edge so back-to-back items keep it high
    task automatic push_item(t_opcode op, t_axis ax, logic signed [ANGLE_W-1:0] ang,
                             logic signed [COMP_W-1:0] vx, logic signed [COMP_W-1:0] vy,
                             logic signed [COMP_W-1:0] vz);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_axis     <= ax;
        i_angle    <= ang;
        i_in_x     <= vx;
        i_in_y     <= vy;
        i_in_z     <= vz;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (op == OP_BAD || (op != OP_NONE && ax == AX_BAD)) n_error++;
        else if (op == OP_NONE) n_bypass++;
        else n_rotate++;
    endtask

    // component mix: rails, small values near zero, and full-range values
    function automatic logic signed [COMP_W-1:0] pick_component();
        int v;
        case ($urandom_range(9))
            0: return COMP_MAX;
            1: return COMP_MIN;
            2, 3, 4: begin
                v = int'($urandom_range(131071)) - 65536;
                return v[COMP_W-1:0];
            end
            default: begin
                v = $urandom;
                return v[COMP_W-1:0];
            end
        endcase
    endfunction

    // mostly rotations on valid axes, with some pass-through and error codes mixed in
    task automatic send_random_item();
        int                        r;
        t_opcode                   op;
        t_axis                     ax;
        logic signed [ANGLE_W-1:0] ang;
        r = $urandom_range(99);
        if (r < 8) op = OP_NONE;
        else if (r < 13) op = OP_BAD;
        else if (r < 56) op = OP_CCW;
        else op = OP_CW;
        if ($urandom_range(99) < 6) ax = AX_BAD;
        else ax = t_axis'($urandom_range(2));
        r   = $urandom;
        ang = r[ANGLE_W-1:0];
        // now and then land on the fold thresholds and the ends of the angle range
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(7))
                0: ang = -16'sd32768;
                1: ang = 16'sd32767;
                2: ang = 16'sd16384;
                3: ang = -16'sd16384;
                4: ang = 16'sd16385;
                5: ang = -16'sd16385;
                6: ang = 16'sd0;
                default: ang = -16'sd1;
            endcase
        end
        push_item(op, ax, ang, pick_component(), pick_component(), pick_component());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: pass-through and error codes with rail values
        push_item(OP_NONE, AX_BAD, -16'sd32768, COMP_MAX, COMP_MIN, 24'sd0);
        push_item(OP_NONE, AX_Z, 16'sd12345, COMP_MIN, COMP_MAX, -24'sd1);
        push_item(OP_BAD, AX_X, 16'sd8192, 24'sd1, 24'sd2, 24'sd3);
        push_item(OP_BAD, AX_BAD, 16'sd0, COMP_MAX, COMP_MAX, COMP_MAX);
        push_item(OP_CCW, AX_BAD, 16'sd4096, 24'sd100, 24'sd200, 24'sd300);
        push_item(OP_CW, AX_BAD, -16'sd4096, COMP_MIN, 24'sd0, COMP_MAX);
        // directed: each axis and direction around zero, the quarter turn and the half turn
        push_item(OP_CCW, AX_X, 16'sd0, 24'sd4096, -24'sd4096, 24'sd8192);
        push_item(OP_CCW, AX_Y, 16'sd16384, 24'sd4096, 24'sd12288, -24'sd8192);
        push_item(OP_CCW, AX_Z, 16'sd16385, 24'sd40960, 24'sd20480, 24'sd7);
        push_item(OP_CW, AX_X, -16'sd16384, 24'sd5, -24'sd409600, 24'sd204800);
        push_item(OP_CW, AX_Y, -16'sd16385, -24'sd300000, 24'sd9, 24'sd123456);
        push_item(OP_CCW, AX_Z, 16'sd32767, 24'sd1000000, -24'sd2000000, 24'sd0);
        push_item(OP_CCW, AX_Z, -16'sd32768, -24'sd777777, 24'sd333333, 24'sd1);
        // clockwise by the most negative angle wraps to the same half turn
        push_item(OP_CW, AX_Z, -16'sd32768, -24'sd777777, 24'sd333333, 24'sd1);
        push_item(OP_CW, AX_X, 16'sd32767, 24'sd0, COMP_MAX, COMP_MIN);
        // directed: 45 degrees on full-scale pairs pushes one component past the rail, then other rail and zero cases
        push_item(OP_CCW, AX_Z, 16'sd8192, COMP_MAX, COMP_MAX, 24'sd0);
        push_item(OP_CW, AX_Y, 16'sd8192, COMP_MIN, COMP_MIN, COMP_MIN);
        push_item(OP_CCW, AX_X, -16'sd8192, 24'sd0, COMP_MIN, COMP_MAX);
        push_item(OP_CCW, AX_Y, 16'sd1, COMP_MAX, COMP_MIN, COMP_MAX);
        push_item(OP_CW, AX_Z, -16'sd1, 24'sd0, 24'sd0, 24'sd0);
        push_item(OP_CCW, AX_Z, 16'sd16384, COMP_MIN, 24'sd0, 24'sd0);
        push_item(OP_CW, AX_X, 16'sd24576, -24'sd1, 24'sd1, -24'sd1);

        // random, sender idles lightly and the receiver stalls often
        repeat (RANDOM_PER_PHASE) send_random_item();

        // random, the other way round
        send_idle_pct = 60;
        recv_idle_pct = 7;
        repeat (RANDOM_PER_PHASE) send_random_item();

        // random, both sides at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) send_random_item();
        i_in_valid <= 1'b0;

        // drain: every prediction answered, then a pipeline's worth of quiet cycles
        do @(posedge i_clk); while (pending != 0);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);

        $display("summary: %0d items over three pacing phases, %0d results compared",
                 items_sent, checked);
        $display("summary: %0d rotations, %0d pass-through, %0d error codes",
                 n_rotate, n_bypass, n_error);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
